[hw/rtl/mm_pkg.sv]
// Shared types, constants and helpers for the matrix product engine.
`timescale 1ns / 1ps

package mm_pkg;

  // Store bounds
  localparam int MAX_ROWS  = 16;
  localparam int MAX_INNER = 16;
  localparam int MAX_COLS  = 16;

  // Store geometry: A is rows x inner, B is inner x cols, row-major
  localparam int A_DEPTH = MAX_ROWS * MAX_INNER;
  localparam int B_DEPTH = MAX_INNER * MAX_COLS;
  localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;

  // Field widths fixed by the interface
  localparam int IDX_W  = 4;
  localparam int VAL_W  = 32;
  localparam int KIND_W = 2;
  localparam int CFG_W  = 5;
  localparam int REG_W  = 2;
  localparam int FRAC_W = 16;

  // Holds register values (up to 31) and store bounds (16)
  localparam int DIM_W = 7;

  // Exact sum of MAX_INNER Q32.32 products
  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = PROD_W + $clog2(MAX_INNER + 1);

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_WR_A    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WR_B    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

  // Register indexes
  localparam logic [REG_W-1:0] REG_A_ROWS    = 2'd0;
  localparam logic [REG_W-1:0] REG_INNER_LEN = 2'd1;
  localparam logic [REG_W-1:0] REG_OUT_COLS  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_HOLD
  } mm_state_t;

  // Clamped sizes
  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] len;
    logic [DIM_W-1:0] cols;
  } mm_dims_t;

  // Store write request
  typedef struct packed {
    logic             a_we;
    logic             b_we;
    logic [A_AW-1:0]  a_addr;
    logic [B_AW-1:0]  b_addr;
    logic [VAL_W-1:0] data;
  } mm_wr_t;

  // Store read request, one per inner index
  typedef struct packed {
    logic            valid;
    logic            last;
    logic [A_AW-1:0] a_addr;
    logic [B_AW-1:0] b_addr;
  } mm_rd_t;

  // Request being answered
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             err;
  } mm_req_t;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [CFG_W-1:0] v, int bound);
    logic [DIM_W-1:0] b;
    b = DIM_W'(bound);
    return (DIM_W'(v) > b) ? b : DIM_W'(v);
  endfunction

endpackage

[hw/rtl/matrix_multiply.sv]
// Top level of the matrix product engine: config registers, stores, output word.
// Write words are stored as they are taken, while no compute is in work. A compute word
// with inner length L makes L reads of one A and one B element through the single
// multiply-accumulate, then passes the read, multiply and sum registers to its result;
// errors and L = 0 skip the reads. One word is in work at a time: a compute holds the
// input until its result is loaded into a free output register. Synchronous active-high
// reset sets all sizes to 16 and empties the output; the stores are not cleared.
`timescale 1ns / 1ps

module matrix_multiply (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // row[3:0], col[7:4], value[39:8]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  // result words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // result[31:0], out_row[35:32], out_col[39:36]
  output logic [0:0]  m_tuser,   // index_error[0]
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  localparam int VW = mm_pkg::VAL_W;
  localparam int IW = mm_pkg::IDX_W;

  // Size registers, raw as written
  logic [mm_pkg::CFG_W-1:0] a_rows, inner_len, out_cols;
  mm_pkg::mm_dims_t dims;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows    <= mm_pkg::CFG_W'(16);
      inner_len <= mm_pkg::CFG_W'(16);
      out_cols  <= mm_pkg::CFG_W'(16);
    end else if (cfg_we) begin
      case (cfg_index)
        mm_pkg::REG_A_ROWS:    a_rows    <= cfg_data;
        mm_pkg::REG_INNER_LEN: inner_len <= cfg_data;
        mm_pkg::REG_OUT_COLS:  out_cols  <= cfg_data;
        default: ;  // no register there
      endcase
    end
  end

  // Sizes beyond the store act as the store bound
  assign dims.rows = mm_pkg::clamp_dim(a_rows, mm_pkg::MAX_ROWS);
  assign dims.len  = mm_pkg::clamp_dim(inner_len, mm_pkg::MAX_INNER);
  assign dims.cols = mm_pkg::clamp_dim(out_cols, mm_pkg::MAX_COLS);

  mm_pkg::mm_wr_t  wr;
  mm_pkg::mm_rd_t  rd;
  mm_pkg::mm_req_t req;
  logic            clear, load_out, mac_done, out_free;
  logic [VW-1:0]   a_data, b_data, mac_result;

  // Output register frees up when empty or being taken
  assign out_free = !m_tvalid || m_tready;

  mm_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .kind     (s_tuser),
    .row      (s_tdata[IW-1:0]),
    .col      (s_tdata[2*IW-1:IW]),
    .value    (s_tdata[2*IW+VW-1:2*IW]),
    .dims     (dims),
    .mac_done (mac_done),
    .out_free (out_free),
    .wr       (wr),
    .rd       (rd),
    .clear    (clear),
    .load_out (load_out),
    .req      (req)
  );

  // A store, row-major rows x inner
  mm_ram #(.DEPTH(mm_pkg::A_DEPTH), .WIDTH(VW)) u_a_store (
    .clk   (clk),
    .we    (wr.a_we),
    .waddr (wr.a_addr),
    .wdata (wr.data),
    .re    (rd.valid),
    .raddr (rd.a_addr),
    .rdata (a_data)
  );

  // B store, row-major inner x cols
  mm_ram #(.DEPTH(mm_pkg::B_DEPTH), .WIDTH(VW)) u_b_store (
    .clk   (clk),
    .we    (wr.b_we),
    .waddr (wr.b_addr),
    .wdata (wr.data),
    .re    (rd.valid),
    .raddr (rd.b_addr),
    .rdata (b_data)
  );

  mm_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .clear  (clear),
    .rd     (rd),
    .a_data (a_data),
    .b_data (b_data),
    .done   (mac_done),
    .result (mac_result)
  );

  // Result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata[VW-1:0]           <= req.err ? '0 : mac_result;  // out of range reads as zero
      m_tdata[VW+IW-1:VW]       <= req.row;
      m_tdata[VW+2*IW-1:VW+IW]  <= req.col;
      m_tuser[0]                <= req.err;
    end
  end

endmodule

[hw/rtl/mm_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module mm_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/mm_mac.sv]
// Multiply-accumulate unit: registered product, exact sum, Q16.16 saturation.
`timescale 1ns / 1ps

module mm_mac (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      clear,
  input  mm_pkg::mm_rd_t            rd,
  input  logic [mm_pkg::VAL_W-1:0]  a_data,
  input  logic [mm_pkg::VAL_W-1:0]  b_data,
  output logic                      done,
  output logic [mm_pkg::VAL_W-1:0]  result
);

  localparam int AW = mm_pkg::ACC_W;
  localparam int PW = mm_pkg::PROD_W;
  localparam int VW = mm_pkg::VAL_W;
  localparam int FW = mm_pkg::FRAC_W;
  localparam int TOP = VW + FW - 1;

  logic                 rd_valid, rd_last;
  logic                 prod_valid, prod_last;
  logic signed [PW-1:0] prod;
  logic        [AW-1:0] acc;
  logic                 fits;

  // read data is registered in the RAM and arrives in the cycle after the request
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      rd_last    <= 1'b0;
      prod_valid <= 1'b0;
      prod_last  <= 1'b0;
      done       <= 1'b0;
    end else begin
      rd_valid   <= rd.valid;
      rd_last    <= rd.last;
      prod_valid <= rd_valid;
      prod_last  <= rd_last;
      done       <= prod_valid && prod_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      prod <= signed'(a_data) * signed'(b_data);
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + {{(AW - PW){prod[PW-1]}}, prod};
    end
  end

  // floor(acc / 2^16) fits 32 bits when the bits above it match its sign
  assign fits = (&acc[AW-1:TOP]) || !(|acc[AW-1:TOP]);

  always_comb begin
    if (fits) begin
      result = acc[TOP:FW];
    end else if (acc[AW-1]) begin
      result = {1'b1, {(VW - 1){1'b0}}};
    end else begin
      result = {1'b0, {(VW - 1){1'b1}}};
    end
  end

endmodule

[hw/rtl/mm_seq.sv]
// Sequencer: decodes items, drives store writes and walks the inner index.
`timescale 1ns / 1ps

module mm_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [mm_pkg::KIND_W-1:0] kind,
  input  logic [mm_pkg::IDX_W-1:0]  row,
  input  logic [mm_pkg::IDX_W-1:0]  col,
  input  logic [mm_pkg::VAL_W-1:0]  value,
  input  mm_pkg::mm_dims_t          dims,
  input  logic                      mac_done,
  input  logic                      out_free,
  output mm_pkg::mm_wr_t            wr,
  output mm_pkg::mm_rd_t            rd,
  output logic                      clear,
  output logic                      load_out,
  output mm_pkg::mm_req_t           req
);

  localparam int DW = mm_pkg::DIM_W;

  mm_pkg::mm_state_t state, state_next;

  logic [DW-1:0]           k;
  logic [DW-1:0]           len_q;
  logic [mm_pkg::IDX_W-1:0] row_q, col_q;
  logic                    err_q;
  logic                    take, is_compute, req_err, last_k;

  assign take       = in_valid && (state == mm_pkg::ST_IDLE);
  assign is_compute = (kind == mm_pkg::KIND_COMPUTE);
  assign req_err    = (DW'(row) >= dims.rows) || (DW'(col) >= dims.cols);
  assign last_k     = (k == len_q - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mm_pkg::ST_IDLE: begin
        if (take && is_compute) begin
          state_next = (req_err || dims.len == '0) ? mm_pkg::ST_HOLD : mm_pkg::ST_RUN;
        end
      end
      mm_pkg::ST_RUN: begin
        if (last_k) state_next = mm_pkg::ST_DRAIN;
      end
      mm_pkg::ST_DRAIN: begin
        if (mac_done) state_next = mm_pkg::ST_HOLD;
      end
      mm_pkg::ST_HOLD: begin
        if (out_free) state_next = mm_pkg::ST_IDLE;
      end
      default: state_next = mm_pkg::ST_IDLE;
    endcase
  end

  // Request registers
  always_ff @(posedge clk) begin
    if (take && is_compute) begin
      row_q <= row;
      col_q <= col;
      len_q <= dims.len;
      err_q <= req_err;
      k     <= '0;
    end else if (state == mm_pkg::ST_RUN) begin
      k <= k + 1'b1;
    end
  end

  always_comb begin
    in_ready  = 1'b0;
    clear     = 1'b0;
    load_out  = 1'b0;
    wr.a_we   = 1'b0;
    wr.b_we   = 1'b0;
    wr.a_addr = mm_pkg::A_AW'(int'(row) * mm_pkg::MAX_INNER + int'(col));
    wr.b_addr = mm_pkg::B_AW'(int'(row) * mm_pkg::MAX_COLS + int'(col));
    wr.data   = value;
    rd.valid  = 1'b0;
    rd.last   = last_k;
    rd.a_addr = mm_pkg::A_AW'(int'(row_q) * mm_pkg::MAX_INNER + int'(k));
    rd.b_addr = mm_pkg::B_AW'(int'(k) * mm_pkg::MAX_COLS + int'(col_q));
    unique case (state)
      mm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (take) begin
          clear   = is_compute;
          // writes beyond the store bounds are dropped
          wr.a_we = (kind == mm_pkg::KIND_WR_A) &&
                    (DW'(row) < DW'(mm_pkg::MAX_ROWS)) && (DW'(col) < DW'(mm_pkg::MAX_INNER));
          wr.b_we = (kind == mm_pkg::KIND_WR_B) &&
                    (DW'(row) < DW'(mm_pkg::MAX_INNER)) && (DW'(col) < DW'(mm_pkg::MAX_COLS));
        end
      end
      mm_pkg::ST_RUN:   rd.valid = 1'b1;
      mm_pkg::ST_DRAIN: ;
      mm_pkg::ST_HOLD:  load_out = out_free;
      default: ;
    endcase
  end

  assign req.row = row_q;
  assign req.col = col_q;
  assign req.err = err_q;

endmodule

[hw/rtl/mm_checker.sv]
// Port-level checks for the matrix product engine, bound to the top level.
`timescale 1ns / 1ps

module mm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [39:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [0:0]  m_tuser,
  input logic        cfg_we,
  input logic [1:0]  cfg_index,
  input logic [4:0]  cfg_data
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // an index error always carries a zero result
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[31:0] == 32'd0)
    else $error("index error with nonzero result");

  // a compute word keeps the input closed for at least the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == mm_pkg::KIND_COMPUTE |=> !s_tready)
    else $error("input open right after compute word");

  // a new result shows only after a busy cycle
  a_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared without a compute in progress");

endmodule

bind matrix_multiply mm_checker u_mm_checker (.*);
